>>> rtl/core/rsz_pkg.sv
// Shared types, constants and register codes for the bilinear resize block.
package rsz_pkg;

  localparam int DEF_MAX_SRC_WIDTH  = 512;
  localparam int DEF_MAX_SRC_HEIGHT = 512;
  localparam int DEF_FRAC_BITS      = 16;

  localparam int POS_W      = 12;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SRC_REG_W  = 10;
  localparam int DST_REG_W  = 13;
  localparam int SIZE_W     = 13;
  localparam int MAX_DST    = 4096;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_REQ  = 1'b1
  } op_t;

  // Image sizes after clamping to their legal ranges.
  typedef struct packed {
    logic [SIZE_W-1:0] sw;
    logic [SIZE_W-1:0] sh;
    logic [SIZE_W-1:0] dw;
    logic [SIZE_W-1:0] dh;
  } sizes_t;

endpackage

>>> rtl/core/rsz_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rsz_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/core/rsz_div.sv
// Restoring divider, one quotient bit per cycle, for the scale ratios.
module rsz_div #(
  parameter int DW = 25,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] den_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          take;

  assign trial = {rem_r, quo_r[DW-1]};
  assign take  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], take};
      rem_r <= take ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/rsz_fifo.sv
// Short queue that decouples the front end from the back end.
module rsz_fifo #(
  parameter int W     = 64,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [PW:0]   cnt_r;
  logic [PW:0]   cnt_nxt;

  assign empty = cnt_r == '0;
  assign full  = cnt_r == (PW + 1)'(DEPTH);
  assign dout  = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

>>> rtl/core/rsz_front.sv
// Front end: classifies items, clamps request positions and maps them to the source.
module rsz_front #(
  parameter int MAX_SRC_WIDTH  = rsz_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = rsz_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int FRAC_BITS      = rsz_pkg::DEF_FRAC_BITS,
  localparam int SZB = $clog2(((MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                               MAX_SRC_WIDTH : MAX_SRC_HEIGHT) + 1),
  localparam int RW  = SZB + FRAC_BITS,
  localparam int SXW = RW + rsz_pkg::POS_W,
  localparam int EW  = 1 + 2 * rsz_pkg::POS_W + 2 * SXW + rsz_pkg::PIX_W
) (
  input  logic                        accept,
  input  logic                        req_type,
  input  logic [rsz_pkg::POS_W-1:0]   pos_x,
  input  logic [rsz_pkg::POS_W-1:0]   pos_y,
  input  logic [rsz_pkg::PIX_W-1:0]   rgb,
  input  rsz_pkg::sizes_t             sizes,
  input  logic [RW-1:0]               x_ratio,
  input  logic [RW-1:0]               y_ratio,
  output logic                        push,
  output logic [EW-1:0]               entry
);

  rsz_pkg::op_t              op;
  logic [rsz_pkg::POS_W-1:0] cx;
  logic [rsz_pkg::POS_W-1:0] cy;
  logic [rsz_pkg::POS_W-1:0] dwm1;
  logic [rsz_pkg::POS_W-1:0] dhm1;
  logic [SXW-1:0]            sx;
  logic [SXW-1:0]            sy;
  logic                      in_src;

  assign op   = req_type ? rsz_pkg::OP_REQ : rsz_pkg::OP_LOAD;
  assign dwm1 = rsz_pkg::POS_W'(sizes.dw - rsz_pkg::SIZE_W'(1));
  assign dhm1 = rsz_pkg::POS_W'(sizes.dh - rsz_pkg::SIZE_W'(1));

  always_comb begin
    if (op == rsz_pkg::OP_REQ) begin
      cx = (pos_x > dwm1) ? dwm1 : pos_x;
      cy = (pos_y > dhm1) ? dhm1 : pos_y;
    end else begin
      cx = pos_x;
      cy = pos_y;
    end
  end

  assign in_src = (rsz_pkg::SIZE_W'(pos_x) < sizes.sw) &&
                  (rsz_pkg::SIZE_W'(pos_y) < sizes.sh);

  assign sx = SXW'(x_ratio) * SXW'(cx);
  assign sy = SXW'(y_ratio) * SXW'(cy);

  // Loads that fall outside the source are dropped here.
  assign push  = accept && ((op == rsz_pkg::OP_REQ) || in_src);
  assign entry = {op, cx, cy, sx, sy, rgb};

endmodule

>>> rtl/core/rsz_back.sv
// Back end: neighbour fetch from four banks, bilinear blend and result register.
module rsz_back #(
  parameter int MAX_SRC_WIDTH  = rsz_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = rsz_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int FRAC_BITS      = rsz_pkg::DEF_FRAC_BITS,
  localparam int SZB = $clog2(((MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                               MAX_SRC_WIDTH : MAX_SRC_HEIGHT) + 1),
  localparam int RW  = SZB + FRAC_BITS,
  localparam int SXW = RW + rsz_pkg::POS_W,
  localparam int EW  = 1 + 2 * rsz_pkg::POS_W + 2 * SXW + rsz_pkg::PIX_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [EW-1:0]             entry,
  input  rsz_pkg::sizes_t           sizes,
  output logic                      out_valid,
  output logic [rsz_pkg::POS_W-1:0] out_x,
  output logic [rsz_pkg::POS_W-1:0] out_y,
  output logic [rsz_pkg::CH_W-1:0]  out_red,
  output logic [rsz_pkg::CH_W-1:0]  out_green,
  output logic [rsz_pkg::CH_W-1:0]  out_blue
);

  localparam int F   = FRAC_BITS;
  localparam int PW  = rsz_pkg::POS_W;
  localparam int XB  = $clog2(MAX_SRC_WIDTH);
  localparam int YB  = $clog2(MAX_SRC_HEIGHT);
  localparam int IW  = SXW - F;
  localparam int BW  = MAX_SRC_WIDTH / 2 + 1;
  localparam int BH  = MAX_SRC_HEIGHT / 2 + 1;
  localparam int BD  = BW * BH;
  localparam int AW  = $clog2(BD);
  localparam int HW  = 8 + F;
  localparam int HPW = HW + 1;
  localparam int VPW = HW + F + 2;

  rsz_pkg::op_t              e_op;
  logic [PW-1:0]             e_x;
  logic [PW-1:0]             e_y;
  logic [SXW-1:0]            e_sx;
  logic [SXW-1:0]            e_sy;
  logic [rsz_pkg::PIX_W-1:0] e_rgb;
  logic [IW-1:0]             ix;
  logic [IW-1:0]             iy;
  logic [IW-1:0]             swm1;
  logic [IW-1:0]             shm1;
  logic [XB-1:0]             x1;
  logic [YB-1:0]             y1;
  logic [XB:0]               xa;
  logic [YB:0]               ya;
  logic [XB-1:0]             col [2];
  logic [YB-1:0]             row [2];
  logic                      is_req;

  // Stage 1: bank addresses and write strobes.
  logic                      s1_req_r;
  logic [3:0]                s1_we_r;
  logic [AW-1:0]             s1_addr_r [4];
  logic [rsz_pkg::PIX_W-1:0] s1_wdata_r;
  logic [F-1:0]              s1_fx_r;
  logic [F-1:0]              s1_fy_r;
  logic                      s1_xp_r;
  logic                      s1_yp_r;
  logic                      s1_xe_r;
  logic                      s1_ye_r;
  logic [PW-1:0]             s1_ox_r;
  logic [PW-1:0]             s1_oy_r;

  // Stage 2: waits for the registered bank read.
  logic                      s2_req_r;
  logic [F-1:0]              s2_fx_r;
  logic [F-1:0]              s2_fy_r;
  logic                      s2_xp_r;
  logic                      s2_yp_r;
  logic                      s2_xe_r;
  logic                      s2_ye_r;
  logic [PW-1:0]             s2_ox_r;
  logic [PW-1:0]             s2_oy_r;
  logic [rsz_pkg::PIX_W-1:0] rd [4];

  // Stage 3: horizontal blends.
  logic                      s3_req_r;
  logic [F-1:0]              s3_fy_r;
  logic [PW-1:0]             s3_ox_r;
  logic [PW-1:0]             s3_oy_r;
  logic [HW-1:0]             s3_top_r [3];
  logic [HW-1:0]             s3_bot_r [3];
  logic [HW-1:0]             top_nxt [3];
  logic [HW-1:0]             bot_nxt [3];
  logic [rsz_pkg::PIX_W-1:0] p11;
  logic [rsz_pkg::PIX_W-1:0] p21;
  logic [rsz_pkg::PIX_W-1:0] p12;
  logic [rsz_pkg::PIX_W-1:0] p22;
  logic [F:0]                wfx;
  logic [F:0]                wfy;
  logic [rsz_pkg::CH_W-1:0]  chan_nxt [3];

  // Stage 4: result register.
  logic                      out_valid_r;
  logic [PW-1:0]             out_x_r;
  logic [PW-1:0]             out_y_r;
  logic [rsz_pkg::CH_W-1:0]  chan_r [3];

  assign e_op  = rsz_pkg::op_t'(entry[EW-1]);
  assign e_x   = entry[EW-2 -: PW];
  assign e_y   = entry[EW-2-PW -: PW];
  assign e_sx  = entry[2*SXW+rsz_pkg::PIX_W-1 -: SXW];
  assign e_sy  = entry[SXW+rsz_pkg::PIX_W-1 -: SXW];
  assign e_rgb = entry[rsz_pkg::PIX_W-1:0];

  assign is_req = e_op == rsz_pkg::OP_REQ;
  assign ix     = e_sx[SXW-1:F];
  assign iy     = e_sy[SXW-1:F];
  assign swm1   = IW'(sizes.sw - rsz_pkg::SIZE_W'(1));
  assign shm1   = IW'(sizes.sh - rsz_pkg::SIZE_W'(1));

  always_comb begin
    if (is_req) begin
      x1 = (ix > swm1) ? XB'(swm1) : XB'(ix);
      y1 = (iy > shm1) ? YB'(shm1) : YB'(iy);
    end else begin
      x1 = e_x[XB-1:0];
      y1 = e_y[YB-1:0];
    end
    xa = {1'b0, x1} + (XB + 1)'(1);
    ya = {1'b0, y1} + (YB + 1)'(1);
    // Each parity bank serves either x1 or x1 + 1, whichever has that parity.
    for (int p = 0; p < 2; p++) begin
      col[p] = (x1[0] == 1'(p)) ? XB'(x1 >> 1) : XB'(xa >> 1);
      row[p] = (y1[0] == 1'(p)) ? YB'(y1 >> 1) : YB'(ya >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_req_r <= 1'b0;
      s1_we_r  <= '0;
      s2_req_r <= 1'b0;
      s3_req_r <= 1'b0;
    end else begin
      s1_req_r <= in_valid && is_req;
      for (int b = 0; b < 4; b++) begin
        s1_we_r[b] <= in_valid && !is_req && (x1[0] == b[0]) && (y1[0] == b[1]);
      end
      s2_req_r <= s1_req_r;
      s3_req_r <= s2_req_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      s1_addr_r[b] <= AW'(row[b / 2]) * AW'(BW) + AW'(col[b % 2]);
    end
    s1_wdata_r <= e_rgb;
    s1_fx_r    <= e_sx[F-1:0];
    s1_fy_r    <= e_sy[F-1:0];
    s1_xp_r    <= x1[0];
    s1_yp_r    <= y1[0];
    s1_xe_r    <= (rsz_pkg::SIZE_W'(x1) + rsz_pkg::SIZE_W'(1)) >= sizes.sw;
    s1_ye_r    <= (rsz_pkg::SIZE_W'(y1) + rsz_pkg::SIZE_W'(1)) >= sizes.sh;
    s1_ox_r    <= e_x;
    s1_oy_r    <= e_y;

    s2_fx_r <= s1_fx_r;
    s2_fy_r <= s1_fy_r;
    s2_xp_r <= s1_xp_r;
    s2_yp_r <= s1_yp_r;
    s2_xe_r <= s1_xe_r;
    s2_ye_r <= s1_ye_r;
    s2_ox_r <= s1_ox_r;
    s2_oy_r <= s1_oy_r;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    rsz_ram #(
      .WIDTH(rsz_pkg::PIX_W),
      .DEPTH(BD)
    ) u_ram (
      .clk  (clk),
      .we   (s1_we_r[b]),
      .waddr(s1_addr_r[b]),
      .wdata(s1_wdata_r),
      .raddr(s1_addr_r[b]),
      .rdata(rd[b])
    );
  end

  // Bank index is {row parity, column parity}; an edge neighbour repeats the near one.
  always_comb begin
    p11 = rd[{s2_yp_r, s2_xp_r}];
    p21 = s2_xe_r ? p11 : rd[{s2_yp_r, ~s2_xp_r}];
    p12 = s2_ye_r ? p11 : rd[{~s2_yp_r, s2_xp_r}];
    if (s2_xe_r) begin
      p22 = p12;
    end else if (s2_ye_r) begin
      p22 = p21;
    end else begin
      p22 = rd[{~s2_yp_r, ~s2_xp_r}];
    end
    wfx = (F + 1)'(1) << F;
    wfx = wfx - {1'b0, s2_fx_r};
    for (int c = 0; c < 3; c++) begin
      top_nxt[c] = HW'(HPW'(p11[8*(2-c) +: 8]) * HPW'(wfx) +
                       HPW'(p21[8*(2-c) +: 8]) * HPW'({1'b0, s2_fx_r}));
      bot_nxt[c] = HW'(HPW'(p12[8*(2-c) +: 8]) * HPW'(wfx) +
                       HPW'(p22[8*(2-c) +: 8]) * HPW'({1'b0, s2_fx_r}));
    end
  end

  always_ff @(posedge clk) begin
    s3_fy_r <= s2_fy_r;
    s3_ox_r <= s2_ox_r;
    s3_oy_r <= s2_oy_r;
    for (int c = 0; c < 3; c++) begin
      s3_top_r[c] <= top_nxt[c];
      s3_bot_r[c] <= bot_nxt[c];
    end
  end

  // The vertical blend is exact, so the byte is simply the bits above 2*F.
  always_comb begin
    logic [VPW-1:0] v;
    wfy = (F + 1)'(1) << F;
    wfy = wfy - {1'b0, s3_fy_r};
    for (int c = 0; c < 3; c++) begin
      v = VPW'(s3_top_r[c]) * VPW'(wfy) + VPW'(s3_bot_r[c]) * VPW'({1'b0, s3_fy_r});
      chan_nxt[c] = v[2*F +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_req_r;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r <= s3_ox_r;
    out_y_r <= s3_oy_r;
    for (int c = 0; c < 3; c++) begin
      chan_r[c] <= chan_nxt[c];
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_red   = chan_r[0];
  assign out_green = chan_r[1];
  assign out_blue  = chan_r[2];

endmodule

>>> rtl/core/bilinear_image_resize_top.sv
// Top level of the bilinear RGB image resizer.
//
// Items enter on start/busy: a transaction is taken at a clock edge with start high
// and busy low. in_req_type low loads one source pixel (ignored outside the source
// size); high requests one destination pixel, whose position is clamped to the
// destination size. Each request gives one result, shown on the out_ ports for a
// single cycle with out_valid high; the receiver cannot stall, so nothing backs up.
// Throughput is one item per clock while busy is low. A request's result passes through
// the queue, the address stage, the registered read of four parity banks and the
// horizontal blend; the vertical blend feeds the result register.
// Loads are visible to any later request.
// Configuration is written on the cfg_ channel while the block is idle. Each write to
// a size register starts a recalculation of both scale ratios by bit-serial dividers;
// meanwhile cfg_ready is low and busy is high. Reset sets all sizes to 512 and both
// ratios to one; the frame store contents are undefined until written.
module bilinear_image_resize_top #(
  parameter int MAX_SRC_WIDTH  = rsz_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = rsz_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int FRAC_BITS      = rsz_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [rsz_pkg::POS_W-1:0]      in_pos_x,
  input  logic [rsz_pkg::POS_W-1:0]      in_pos_y,
  input  logic [rsz_pkg::CH_W-1:0]       in_red_in,
  input  logic [rsz_pkg::CH_W-1:0]       in_green_in,
  input  logic [rsz_pkg::CH_W-1:0]       in_blue_in,
  output logic                           out_valid,
  output logic [rsz_pkg::POS_W-1:0]      out_x,
  output logic [rsz_pkg::POS_W-1:0]      out_y,
  output logic [rsz_pkg::CH_W-1:0]       out_red_out,
  output logic [rsz_pkg::CH_W-1:0]       out_green_out,
  output logic [rsz_pkg::CH_W-1:0]       out_blue_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsz_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SZB = $clog2(((MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                               MAX_SRC_WIDTH : MAX_SRC_HEIGHT) + 1);
  localparam int RW  = SZB + FRAC_BITS;
  localparam int SXW = RW + rsz_pkg::POS_W;
  localparam int EW  = 1 + 2 * rsz_pkg::POS_W + 2 * SXW + rsz_pkg::PIX_W;
  localparam int SW  = rsz_pkg::SIZE_W;

  logic [rsz_pkg::SRC_REG_W-1:0] src_w_r;
  logic [rsz_pkg::SRC_REG_W-1:0] src_h_r;
  logic [rsz_pkg::DST_REG_W-1:0] dst_w_r;
  logic [rsz_pkg::DST_REG_W-1:0] dst_h_r;
  logic                          recalc_r;
  logic [RW-1:0]                 x_ratio_r;
  logic [RW-1:0]                 y_ratio_r;
  rsz_pkg::sizes_t               sizes;
  logic                          cfg_we;
  logic                          xdiv_busy;
  logic                          ydiv_busy;
  logic                          xdiv_done;
  logic                          ydiv_done;
  logic [RW-1:0]                 xq;
  logic [RW-1:0]                 yq;
  logic                          accept;
  logic                          push;
  logic [EW-1:0]                 entry_in;
  logic [EW-1:0]                 entry_out;
  logic                          q_empty;
  logic                          q_full;

  // A size of zero counts as one and anything above the maximum as the maximum.
  always_comb begin
    sizes.sw = (src_w_r == '0) ? SW'(1) :
               (SW'(src_w_r) > SW'(MAX_SRC_WIDTH)) ? SW'(MAX_SRC_WIDTH) : SW'(src_w_r);
    sizes.sh = (src_h_r == '0) ? SW'(1) :
               (SW'(src_h_r) > SW'(MAX_SRC_HEIGHT)) ? SW'(MAX_SRC_HEIGHT) : SW'(src_h_r);
    sizes.dw = (dst_w_r == '0) ? SW'(1) :
               (SW'(dst_w_r) > SW'(rsz_pkg::MAX_DST)) ? SW'(rsz_pkg::MAX_DST) : SW'(dst_w_r);
    sizes.dh = (dst_h_r == '0) ? SW'(1) :
               (SW'(dst_h_r) > SW'(rsz_pkg::MAX_DST)) ? SW'(rsz_pkg::MAX_DST) : SW'(dst_h_r);
  end

  // The ratios are only loaded at the edge that ends the done cycle, so hold off until then.
  assign cfg_ready = !(recalc_r || xdiv_busy || ydiv_busy || xdiv_done || ydiv_done);
  assign cfg_we    = cfg_valid && cfg_ready;
  assign busy      = !cfg_ready || q_full;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r   <= rsz_pkg::SRC_REG_W'(512);
      src_h_r   <= rsz_pkg::SRC_REG_W'(512);
      dst_w_r   <= rsz_pkg::DST_REG_W'(512);
      dst_h_r   <= rsz_pkg::DST_REG_W'(512);
      recalc_r  <= 1'b0;
      x_ratio_r <= RW'(1) << FRAC_BITS;
      y_ratio_r <= RW'(1) << FRAC_BITS;
    end else begin
      recalc_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          rsz_pkg::REG_SRC_WIDTH: begin
            src_w_r  <= cfg_data[rsz_pkg::SRC_REG_W-1:0];
            recalc_r <= 1'b1;
          end
          rsz_pkg::REG_SRC_HEIGHT: begin
            src_h_r  <= cfg_data[rsz_pkg::SRC_REG_W-1:0];
            recalc_r <= 1'b1;
          end
          rsz_pkg::REG_DST_WIDTH: begin
            dst_w_r  <= cfg_data;
            recalc_r <= 1'b1;
          end
          rsz_pkg::REG_DST_HEIGHT: begin
            dst_h_r  <= cfg_data;
            recalc_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (xdiv_done) begin
        x_ratio_r <= xq;
      end
      if (ydiv_done) begin
        y_ratio_r <= yq;
      end
    end
  end

  rsz_div #(
    .DW(RW),
    .VW(SW)
  ) u_xdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (recalc_r),
    .dividend(RW'(sizes.sw) << FRAC_BITS),
    .divisor (sizes.dw),
    .busy    (xdiv_busy),
    .done    (xdiv_done),
    .quotient(xq)
  );

  rsz_div #(
    .DW(RW),
    .VW(SW)
  ) u_ydiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (recalc_r),
    .dividend(RW'(sizes.sh) << FRAC_BITS),
    .divisor (sizes.dh),
    .busy    (ydiv_busy),
    .done    (ydiv_done),
    .quotient(yq)
  );

  rsz_front #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_front (
    .accept  (accept),
    .req_type(in_req_type),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .rgb     ({in_red_in, in_green_in, in_blue_in}),
    .sizes   (sizes),
    .x_ratio (x_ratio_r),
    .y_ratio (y_ratio_r),
    .push    (push),
    .entry   (entry_in)
  );

  rsz_fifo #(
    .W    (EW),
    .DEPTH(rsz_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  (entry_in),
    .pop  (!q_empty),
    .dout (entry_out),
    .empty(q_empty),
    .full (q_full)
  );

  rsz_back #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (!q_empty),
    .entry    (entry_out),
    .sizes    (sizes),
    .out_valid(out_valid),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_red  (out_red_out),
    .out_green(out_green_out),
    .out_blue (out_blue_out)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the bilinear RGB image resizer.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_SW = rsz_pkg::DEF_MAX_SRC_WIDTH;
  localparam int MAX_SH = rsz_pkg::DEF_MAX_SRC_HEIGHT;
  localparam int FRAC = rsz_pkg::DEF_FRAC_BITS;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [rsz_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [rsz_pkg::POS_W-1:0] x;
    logic [rsz_pkg::POS_W-1:0] y;
    logic [rsz_pkg::CH_W-1:0] red;
    logic [rsz_pkg::CH_W-1:0] green;
    logic [rsz_pkg::CH_W-1:0] blue;
  } pixel_out_t;

  logic clk, rst_n, start, busy, in_req_type;
  logic [rsz_pkg::POS_W-1:0] in_pos_x, in_pos_y;
  logic [rsz_pkg::CH_W-1:0] in_red_in, in_green_in, in_blue_in;
  logic out_valid;
  logic [rsz_pkg::POS_W-1:0] out_x, out_y;
  logic [rsz_pkg::CH_W-1:0] out_red_out, out_green_out, out_blue_out;
  logic cfg_valid, cfg_ready;
  logic [rsz_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rsz_pkg::CFG_DATA_W-1:0] cfg_data;

  bilinear_image_resize_top dut (.*);

  // Predictor state.
  logic [rsz_pkg::PIX_W-1:0] frame_mem [MAX_SW*MAX_SH];
  bit written [MAX_SW*MAX_SH];
  logic [rsz_pkg::SRC_REG_W-1:0] reg_sw, reg_sh;
  logic [rsz_pkg::DST_REG_W-1:0] reg_dw, reg_dh;
  pixel_out_t pixel_q[$];
  int errors = 0;
  bit idle_en = 1;
  int stall_count = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_size(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int eff_sw(); return clamp_size(int'(reg_sw), MAX_SW); endfunction
  function automatic int eff_sh(); return clamp_size(int'(reg_sh), MAX_SH); endfunction
  function automatic int eff_dw(); return clamp_size(int'(reg_dw), rsz_pkg::MAX_DST); endfunction
  function automatic int eff_dh(); return clamp_size(int'(reg_dh), rsz_pkg::MAX_DST); endfunction

  // Source position of the top-left neighbour and its fraction, along one axis.
  function automatic void map_axis(int s, int d, int p, output int p1, output int p2,
                                   output longint f);
    longint ratio, sp;
    ratio = (longint'(s) << FRAC) / d;
    sp = ratio * p;
    f = sp & ((64'd1 << FRAC) - 1);
    p1 = ((sp >> FRAC) > s - 1) ? s - 1 : int'(sp >> FRAC);
    p2 = (p1 + 1 < s) ? p1 + 1 : p1;
  endfunction

  function automatic logic [7:0] blend_channel(longint a, longint b, longint c, longint d,
                                               longint fx, longint fy);
    longint one, top, bot, v;
    one = 64'd1 << FRAC;
    top = a * (one - fx) + b * fx;
    bot = c * (one - fx) + d * fx;
    v = (top * (one - fy) + bot * fy) >> (2 * FRAC);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic int clamp_pos(int p, int d);
    return (p > d - 1) ? d - 1 : p;
  endfunction

  function automatic pixel_out_t predict_pixel(int px, int py);
    pixel_out_t r;
    int x1, x2, y1, y2;
    longint fx, fy;
    logic [rsz_pkg::PIX_W-1:0] p11, p21, p12, p22;
    px = clamp_pos(px, eff_dw());
    py = clamp_pos(py, eff_dh());
    map_axis(eff_sw(), eff_dw(), px, x1, x2, fx);
    map_axis(eff_sh(), eff_dh(), py, y1, y2, fy);
    p11 = frame_mem[y1*MAX_SW + x1];
    p21 = frame_mem[y1*MAX_SW + x2];
    p12 = frame_mem[y2*MAX_SW + x1];
    p22 = frame_mem[y2*MAX_SW + x2];
    r.x = rsz_pkg::POS_W'(px);
    r.y = rsz_pkg::POS_W'(py);
    r.red = blend_channel(p11[23:16], p21[23:16], p12[23:16], p22[23:16], fx, fy);
    r.green = blend_channel(p11[15:8], p21[15:8], p12[15:8], p22[15:8], fx, fy);
    r.blue = blend_channel(p11[7:0], p21[7:0], p12[7:0], p22[7:0], fx, fy);
    return r;
  endfunction

  // Sends one item and updates the predictor once the transaction is taken.
  task automatic send_item(rsz_pkg::op_t op, int px, int py, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 99) < 29) begin
      start = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_req_type = op;
    in_pos_x = rsz_pkg::POS_W'(px);
    in_pos_y = rsz_pkg::POS_W'(py);
    in_red_in = r;
    in_green_in = g;
    in_blue_in = b;
    start = 1;
    do @(posedge clk); while (busy);
    if (op == rsz_pkg::OP_LOAD) begin
      if (px < eff_sw() && py < eff_sh()) begin
        frame_mem[py*MAX_SW + px] = {r, g, b};
        written[py*MAX_SW + px] = 1;
      end
    end else begin
      pixel_q.push_back(predict_pixel(px, py));
    end
  endtask

  task automatic load_pixel(int px, int py);
    send_item(rsz_pkg::OP_LOAD, px, py, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Loads any neighbour not yet written, so that no undefined entry is read.
  task automatic request_pixel(int px, int py);
    int x1, x2, y1, y2;
    longint fx, fy;
    map_axis(eff_sw(), eff_dw(), clamp_pos(px, eff_dw()), x1, x2, fx);
    map_axis(eff_sh(), eff_dh(), clamp_pos(py, eff_dh()), y1, y2, fy);
    if (!written[y1*MAX_SW + x1]) load_pixel(x1, y1);
    if (!written[y1*MAX_SW + x2]) load_pixel(x2, y1);
    if (!written[y2*MAX_SW + x1]) load_pixel(x1, y2);
    if (!written[y2*MAX_SW + x2]) load_pixel(x2, y2);
    send_item(rsz_pkg::OP_REQ, px, py, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drops start first so that the last item is not taken again while waiting.
  task automatic wait_drained();
    @(negedge clk);
    start = 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rsz_pkg::CFG_IDX_W-1:0] idx,
                           logic [rsz_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    @(negedge clk);
    start = 0;
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rsz_pkg::REG_SRC_WIDTH: reg_sw = val[rsz_pkg::SRC_REG_W-1:0];
      rsz_pkg::REG_SRC_HEIGHT: reg_sh = val[rsz_pkg::SRC_REG_W-1:0];
      rsz_pkg::REG_DST_WIDTH: reg_dw = val;
      rsz_pkg::REG_DST_HEIGHT: reg_dh = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_sizes(int sw, int sh, int dw, int dh);
    write_reg(rsz_pkg::REG_SRC_WIDTH, rsz_pkg::CFG_DATA_W'(sw));
    write_reg(rsz_pkg::REG_SRC_HEIGHT, rsz_pkg::CFG_DATA_W'(sh));
    write_reg(rsz_pkg::REG_DST_WIDTH, rsz_pkg::CFG_DATA_W'(dw));
    write_reg(rsz_pkg::REG_DST_HEIGHT, rsz_pkg::CFG_DATA_W'(dh));
  endtask

  task automatic test_directed();
    set_sizes(4, 3, 8, 5);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 4; x++)
        send_item(rsz_pkg::OP_LOAD, x, y, ((x + y) % 2) ? 8'hFF : 8'h00, 8'hFF, 8'h00);
    send_item(rsz_pkg::OP_LOAD, 4, 0, 8'h12, 8'h34, 8'h56);      // outside the source
    send_item(rsz_pkg::OP_LOAD, 4095, 4095, 8'hFF, 8'hFF, 8'hFF);
    request_pixel(0, 0);
    request_pixel(7, 4);
    request_pixel(3, 2);
    request_pixel(4095, 4095);                           // clamped to the corner
    request_pixel(4095, 0);
    request_pixel(0, 4095);
    // A single source pixel: the right and bottom neighbours fold onto it.
    set_sizes(1, 1, 3, 3);
    request_pixel(2, 2);
    request_pixel(0, 1);
    // Zero and oversized values fall back to their limits.
    write_reg(REG_UNUSED, 13'h1FFF);
    set_sizes(0, 1023, 8191, 0);
    request_pixel(4095, 4095);
    request_pixel(1234, 7);
  endtask

  task automatic random_phase(int sw, int sh, int dw, int dh, int n, bit pause);
    int k;
    set_sizes(sw, sh, dw, dh);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (pause && i == n / 2) wait_drained();
      if (k < 60)
        request_pixel($urandom_range(0, eff_dw() + 8 > 4095 ? 4095 : eff_dw() + 8),
                      $urandom_range(0, eff_dh() + 8 > 4095 ? 4095 : eff_dh() + 8));
      else if (k < 90)
        load_pixel($urandom_range(0, eff_sw() - 1), $urandom_range(0, eff_sh() - 1));
      else
        send_item(rsz_pkg::OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random();
    random_phase(16, 12, 40, 30, 70, 0);
    random_phase(512, 512, 4096, 4096, 60, 1);
    idle_en = 0;
    random_phase(20, 20, 7, 5, 60, 0);
    idle_en = 1;
    random_phase(512, 512, 1, 1, 25, 0);
    random_phase(9, 33, 4095, 2, 60, 0);
    random_phase(1, 64, 100, 64, 50, 0);
  endtask

  always @(posedge clk) begin
    pixel_out_t exp_px, got;
    if (rst_n && out_valid) begin
      got = '{out_x, out_y, out_red_out, out_green_out, out_blue_out};
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
      end else begin
        exp_px = pixel_q.pop_front();
        if (got !== exp_px) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, exp_px, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    start = 0;
    in_req_type = rsz_pkg::OP_LOAD;
    in_pos_x = 0;
    in_pos_y = 0;
    in_red_in = 0;
    in_green_in = 0;
    in_blue_in = 0;
    cfg_valid = 0;
    cfg_index = rsz_pkg::REG_SRC_WIDTH;
    cfg_data = 0;
    reg_sw = 512;
    reg_sh = 512;
    reg_dw = 512;
    reg_dh = 512;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random();
    wait_drained();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
